[hdl/crc8_framed_command_parser_assert.svh]
// Assertion macros for the framed command parser, clocked on i_clk, reset by i_rst_n
`ifndef CRC8_FRAMED_COMMAND_PARSER_ASSERT_SVH
`define CRC8_FRAMED_COMMAND_PARSER_ASSERT_SVH

// ante holds, cons holds in the same cycle
`define CFCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// ante holds, cons holds in the next cycle
`define CFCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[hdl/cfcp_pkg.sv]
package cfcp_pkg;

    localparam int BUF_BYTES = 64;
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CMP_W     = (IDX_W + 2 > 10) ? IDX_W + 2 : 10;
    localparam int LEFT_W    = 9;
    localparam int POS_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_END_ERR  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD     = 3'd0,
        CFG_END      = 3'd1,
        CFG_TYPE_POS = 3'd2,
        CFG_SEQ_POS  = 3'd3,
        CFG_LEN_POS  = 3'd4,
        CFG_CMD_POS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic    start;
        logic    collect;
        logic    crc_init;
        logic    rd_en;
        logic    crc_acc;
        logic    emit_init;
        logic    advance;
        logic    load_out;
        logic    out_param;
        logic    set_stat;
        t_status stat;
    } t_dp_cmd;

    typedef struct packed {
        logic head_match;
        logic overflow;
        logic close;
        logic end_ok;
        logic crc_ok;
        logic plen_zero;
        logic left_one;
        logic out_free;
    } t_dp_sts;

    function automatic logic [BYTE_W-1:0] crc8_step(logic [BYTE_W-1:0] c,
                                                    logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[hdl/cfcp_rx_if.sv]
interface cfcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/cfcp_res_if.sv]
interface cfcp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_type;
    logic [7:0] seq_num;
    logic [7:0] command;
    logic [7:0] param_count;
    logic       has_param;
    logic [7:0] param_byte;
    logic       last;

    modport source (output valid, output status, output frame_type, output seq_num,
                    output command, output param_count, output has_param,
                    output param_byte, output last, input ready);
    modport sink   (input valid, input status, input frame_type, input seq_num,
                    input command, input param_count, input has_param,
                    input param_byte, input last, output ready);
endinterface

[hdl/cfcp_ctrl.sv]
module cfcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  cfcp_pkg::t_dp_sts i_sts,
    output cfcp_pkg::t_dp_cmd o_cmd
);
    import cfcp_pkg::*;

    typedef enum logic [7:0] {
        S_HUNT    = 8'b0000_0001,
        S_COLLECT = 8'b0000_0010,
        S_CRC_RD  = 8'b0000_0100,
        S_CRC_ACC = 8'b0000_1000,
        S_CHECK   = 8'b0001_0000,
        S_ONE     = 8'b0010_0000,
        S_EM_RD   = 8'b0100_0000,
        S_EM_LD   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_rx_ready = (r_state == S_HUNT) || (r_state == S_COLLECT);
    assign w_acc      = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (w_acc && i_sts.head_match) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_COLLECT;
                end
            end
            S_COLLECT: begin
                if (w_acc) begin
                    o_cmd.collect = 1'b1;
                    priority if (i_sts.overflow) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = ST_TOO_LONG;
                        n_state        = S_ONE;
                    end else if (i_sts.close && !i_sts.end_ok) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = ST_END_ERR;
                        n_state        = S_ONE;
                    end else if (i_sts.close) begin
                        o_cmd.crc_init = 1'b1;
                        n_state        = S_CRC_RD;
                    end else begin
                        n_state = S_COLLECT;
                    end
                end
            end
            S_CRC_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CRC_ACC;
            end
            S_CRC_ACC: begin
                o_cmd.crc_acc = 1'b1;
                o_cmd.advance = 1'b1;
                n_state       = i_sts.left_one ? S_CHECK : S_CRC_RD;
            end
            S_CHECK: begin
                priority if (!i_sts.crc_ok) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_CRC_ERR;
                    n_state        = S_ONE;
                end else if (i_sts.plen_zero) begin
                    o_cmd.set_stat = 1'b1;
                    o_cmd.stat     = ST_GOOD;
                    n_state        = S_ONE;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EM_RD;
                end
            end
            S_ONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_HUNT;
                end
            end
            S_EM_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EM_LD;
            end
            S_EM_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_param = 1'b1;
                    o_cmd.advance   = 1'b1;
                    n_state         = i_sts.left_one ? S_HUNT : S_EM_RD;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[hdl/cfcp_dpath.sv]
module cfcp_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cfcp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cfcp_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic [cfcp_pkg::BYTE_W-1:0]        i_rx_byte,
    input  cfcp_pkg::t_dp_cmd                  i_cmd,
    output cfcp_pkg::t_dp_sts                  o_sts,
    cfcp_res_if.source                         o_res
);
    import cfcp_pkg::*;

    logic [BYTE_W-1:0] r_head;
    logic [BYTE_W-1:0] r_end;
    logic [POS_W-1:0]  r_type_pos;
    logic [POS_W-1:0]  r_seq_pos;
    logic [POS_W-1:0]  r_len_pos;
    logic [POS_W-1:0]  r_cmd_pos;

    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_hdr_type, n_hdr_type;
    logic [BYTE_W-1:0] r_hdr_seq, n_hdr_seq;
    logic [BYTE_W-1:0] r_hdr_len, n_hdr_len;
    logic [BYTE_W-1:0] r_hdr_cmd, n_hdr_cmd;
    logic [BYTE_W-1:0] r_last_byte;
    logic [BYTE_W-1:0] r_crc_byte;
    logic [BYTE_W-1:0] r_crc;
    logic [IDX_W-1:0]  r_ptr;
    logic [LEFT_W-1:0] r_left;
    t_status           r_stat;
    logic [BYTE_W-1:0] r_rdata;
    logic [BYTE_W-1:0] r_mem [BUF_BYTES];

    logic              r_out_valid;
    t_status           r_out_status;
    logic [BYTE_W-1:0] r_out_type;
    logic [BYTE_W-1:0] r_out_seq;
    logic [BYTE_W-1:0] r_out_cmd;
    logic [BYTE_W-1:0] r_out_count;
    logic              r_out_has;
    logic [BYTE_W-1:0] r_out_pb;
    logic              r_out_last;

    logic [CNT_W-1:0]  w_i;
    logic [CMP_W-1:0]  w_i_cmp;
    logic [POS_W-1:0]  w_need_a;
    logic [POS_W-1:0]  w_need;
    logic              w_overflow;
    logic              w_collect;

    assign w_i        = {1'b0, r_idx} + CNT_W'(1);
    assign w_i_cmp    = CMP_W'(w_i);
    assign w_overflow = w_i >= CNT_W'(BUF_BYTES);
    assign w_collect  = i_cmd.collect && !w_overflow;

    assign n_hdr_type = (w_i_cmp == CMP_W'(r_type_pos)) ? i_rx_byte : r_hdr_type;
    assign n_hdr_seq  = (w_i_cmp == CMP_W'(r_seq_pos))  ? i_rx_byte : r_hdr_seq;
    assign n_hdr_len  = (w_i_cmp == CMP_W'(r_len_pos))  ? i_rx_byte : r_hdr_len;
    assign n_hdr_cmd  = (w_i_cmp == CMP_W'(r_cmd_pos))  ? i_rx_byte : r_hdr_cmd;

    assign w_need_a = (r_seq_pos > r_type_pos) ? r_seq_pos : r_type_pos;
    assign w_need   = (r_len_pos > w_need_a) ? r_len_pos : w_need_a;

    assign o_sts.head_match = i_rx_byte == r_head;
    assign o_sts.overflow   = w_overflow;
    assign o_sts.close      = (w_i_cmp >= CMP_W'(w_need)) &&
                              (w_i_cmp >= CMP_W'(r_cmd_pos) + CMP_W'(n_hdr_len) + CMP_W'(2));
    assign o_sts.end_ok     = i_rx_byte == r_end;
    assign o_sts.crc_ok     = r_crc == r_crc_byte;
    assign o_sts.plen_zero  = r_hdr_len == '0;
    assign o_sts.left_one   = r_left == LEFT_W'(1);
    assign o_sts.out_free   = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_end       <= '0;
            r_type_pos  <= POS_W'(1);
            r_seq_pos   <= POS_W'(2);
            r_len_pos   <= POS_W'(3);
            r_cmd_pos   <= POS_W'(4);
            r_idx       <= '0;
            r_hdr_type  <= '0;
            r_hdr_seq   <= '0;
            r_hdr_len   <= '0;
            r_hdr_cmd   <= '0;
            r_crc       <= '0;
            r_ptr       <= '0;
            r_left      <= '0;
            r_stat      <= ST_GOOD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEAD:     r_head     <= i_cfg_data;
                    CFG_END:      r_end      <= i_cfg_data;
                    CFG_TYPE_POS: r_type_pos <= i_cfg_data[POS_W-1:0];
                    CFG_SEQ_POS:  r_seq_pos  <= i_cfg_data[POS_W-1:0];
                    CFG_LEN_POS:  r_len_pos  <= i_cfg_data[POS_W-1:0];
                    CFG_CMD_POS:  r_cmd_pos  <= i_cfg_data[POS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.start) begin
                r_idx      <= '0;
                r_hdr_type <= '0;
                r_hdr_seq  <= '0;
                r_hdr_len  <= '0;
                r_hdr_cmd  <= '0;
            end else if (w_collect) begin
                r_idx      <= w_i[IDX_W-1:0];
                r_hdr_type <= n_hdr_type;
                r_hdr_seq  <= n_hdr_seq;
                r_hdr_len  <= n_hdr_len;
                r_hdr_cmd  <= n_hdr_cmd;
            end

            if (i_cmd.crc_init) begin
                r_crc <= '0;
            end else if (i_cmd.crc_acc) begin
                r_crc <= crc8_step(r_crc, r_rdata);
            end

            if (i_cmd.crc_init) begin
                r_ptr  <= IDX_W'(r_cmd_pos);
                r_left <= LEFT_W'(n_hdr_len) + LEFT_W'(1);
            end else if (i_cmd.emit_init) begin
                r_ptr  <= IDX_W'(r_cmd_pos) + IDX_W'(1);
                r_left <= LEFT_W'(r_hdr_len);
            end else if (i_cmd.advance) begin
                r_ptr  <= r_ptr + IDX_W'(1);
                r_left <= r_left - LEFT_W'(1);
            end

            if (i_cmd.set_stat) begin
                r_stat <= i_cmd.stat;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mem[0] <= i_rx_byte;
        end else if (w_collect) begin
            r_mem[w_i[IDX_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    // keep the byte before the newest one: it is the CRC byte when a frame closes
    always_ff @(posedge i_clk) begin
        if (i_cmd.start || w_collect) begin
            r_crc_byte  <= r_last_byte;
            r_last_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_param ? ST_GOOD : r_stat;
            r_out_type   <= r_hdr_type;
            r_out_seq    <= r_hdr_seq;
            r_out_cmd    <= r_hdr_cmd;
            r_out_count  <= r_hdr_len;
            r_out_has    <= i_cmd.out_param;
            r_out_pb     <= i_cmd.out_param ? r_rdata : '0;
            r_out_last   <= i_cmd.out_param ? (r_left == LEFT_W'(1)) : 1'b1;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.frame_type  = r_out_type;
    assign o_res.seq_num     = r_out_seq;
    assign o_res.command     = r_out_cmd;
    assign o_res.param_count = r_out_count;
    assign o_res.has_param   = r_out_has;
    assign o_res.param_byte  = r_out_pb;
    assign o_res.last        = r_out_last;
endmodule

[hdl/crc8_framed_command_parser.sv]
// Framed command parser. Received bytes arrive one transfer at a time on i_rx; the
// block hunts for the head byte, collects the frame into a 64-byte buffer and, on the
// closing byte, checks the end byte and then a reflected CRC-8 (polynomial 0x8C, init 0)
// over the command and parameter bytes. A good frame yields one result per parameter
// byte on o_res (or a single result with no parameter), a bad one a single status
// result. While hunting or collecting a byte is taken every cycle. After the closing
// byte no byte is taken until the frame is finished: the CRC walk reads the command
// byte and the L parameter bytes through the buffer's one registered read port, each
// in a read state and then an accumulate state, and a check state follows; each
// parameter result then takes a read state and a load state. A CRC error, a bad end
// byte or an overlong frame goes to a single result state. The wait grows while o_res
// is stalled. Configuration may be written only while the block is idle.
`include "crc8_framed_command_parser_assert.svh"

module crc8_framed_command_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfcp_pkg::BYTE_W-1:0]    i_cfg_data,
    cfcp_rx_if.sink                        i_rx,
    cfcp_res_if.source                     o_res
);
    import cfcp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_res_err;

    cfcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cfcp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

    assign w_res_err = o_res.valid && (o_res.status != ST_GOOD);

    `CFCP_ASSERT_SAME(a_load_blocks_rx, w_cmd.load_out, !i_rx.ready)
    `CFCP_ASSERT_SAME(a_crc_init_on_collect, w_cmd.crc_init, w_cmd.collect && w_sts.close)
    `CFCP_ASSERT_SAME(a_error_no_param, w_res_err, !o_res.has_param && o_res.last)
    `CFCP_ASSERT_NEXT(a_load_sets_valid, w_cmd.load_out, o_res.valid)
endmodule

[sim/crc8_parser_checker.sv]
`timescale 1ns / 1ps

package cfcp_tb_crc_pkg;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc,
                                               input logic [7:0] data);
        logic [7:0] c;
        int         k;
        c = acc ^ data;
        for (k = 0; k < 8; k++) begin
            c = {1'b0, c[7:1]} ^ (c[0] ? cfcp_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

module crc8_parser_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfcp_pkg::BYTE_W-1:0]    i_cfg_data,
    cfcp_rx_if                             i_rx,
    cfcp_res_if                            i_res,
    output int                             o_errors,
    output int                             o_pending,
    output logic                           o_in_frame,
    output int                             o_bytes,
    output int                             o_results,
    output int                             o_bad_frames
);
    import cfcp_pkg::*;
    import cfcp_tb_crc_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [7:0] frame_type;
        logic [7:0] seq_num;
        logic [7:0] command;
        logic [7:0] param_count;
        logic       has_param;
        logic [7:0] param_byte;
        logic       last;
    } t_frame_result;

    t_frame_result frame_results_due[$];

    logic [7:0]  hunt_head;
    logic [7:0]  close_val;
    logic [3:0]  pos_type;
    logic [3:0]  pos_seq;
    logic [3:0]  pos_len;
    logic [3:0]  pos_cmd;

    logic        collecting;
    int unsigned offset;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_len;
    logic [7:0]  hdr_cmd;
    logic [7:0]  frame_buf [0:BUF_BYTES-1];

    task automatic report_mismatch(input string what);
        o_errors++;
        if (o_errors <= 40) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    function automatic string fmt_result(input t_frame_result r);
        return $sformatf("st=%0d ty=%02h sq=%02h cm=%02h n=%0d hp=%0d pb=%02h l=%0d",
                         r.status, r.frame_type, r.seq_num, r.command, r.param_count,
                         r.has_param, r.param_byte, r.last);
    endfunction

    task automatic push_result(input t_status st, input logic has, input logic [7:0] pb,
                               input logic last);
        t_frame_result r;
        r.status      = st;
        r.frame_type  = hdr_type;
        r.seq_num     = hdr_seq;
        r.command     = hdr_cmd;
        r.param_count = hdr_len;
        r.has_param   = has;
        r.param_byte  = pb;
        r.last        = last;
        frame_results_due.push_back(r);
        if (st != ST_GOOD) begin
            o_bad_frames++;
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        int unsigned i;
        int unsigned need;
        int unsigned plen;
        int unsigned j;
        logic [7:0]  crc;
        if (!collecting) begin
            if (b == hunt_head) begin
                collecting   = 1'b1;
                offset       = 0;
                hdr_type     = 8'h00;
                hdr_seq      = 8'h00;
                hdr_len      = 8'h00;
                hdr_cmd      = 8'h00;
                frame_buf[0] = b;
            end
            return;
        end
        i = offset + 1;
        if (i >= BUF_BYTES) begin
            collecting = 1'b0;
            push_result(ST_TOO_LONG, 1'b0, 8'h00, 1'b1);
            return;
        end
        offset       = i;
        frame_buf[i] = b;
        if (i == pos_type) hdr_type = b;
        if (i == pos_seq)  hdr_seq  = b;
        if (i == pos_len)  hdr_len  = b;
        if (i == pos_cmd)  hdr_cmd  = b;
        need = pos_type;
        if (pos_seq > need) need = pos_seq;
        if (pos_len > need) need = pos_len;
        if (i < need) return;
        plen = hdr_len;
        if (i < pos_cmd + plen + 2) return;

        collecting = 1'b0;
        if (b != close_val) begin
            push_result(ST_END_ERR, 1'b0, 8'h00, 1'b1);
            return;
        end
        crc = 8'h00;
        for (j = 0; j <= plen; j++) begin
            crc = crc8_update(crc, frame_buf[pos_cmd + j]);
        end
        if (crc != frame_buf[i - 1]) begin
            push_result(ST_CRC_ERR, 1'b0, 8'h00, 1'b1);
            return;
        end
        if (plen == 0) begin
            push_result(ST_GOOD, 1'b0, 8'h00, 1'b1);
            return;
        end
        for (j = 0; j < plen; j++) begin
            push_result(ST_GOOD, 1'b1, frame_buf[pos_cmd + 1 + j], j + 1 == plen);
        end
    endtask

    task automatic check_result();
        t_frame_result got;
        t_frame_result want;
        got.status      = t_status'(i_res.status);
        got.frame_type  = i_res.frame_type;
        got.seq_num     = i_res.seq_num;
        got.command     = i_res.command;
        got.param_count = i_res.param_count;
        got.has_param   = i_res.has_param;
        got.param_byte  = i_res.param_byte;
        got.last        = i_res.last;
        o_results++;
        if (frame_results_due.size() == 0) begin
            report_mismatch({"result with none due: ", fmt_result(got)});
            return;
        end
        want = frame_results_due.pop_front();
        if (got !== want) begin
            report_mismatch({"result mismatch: want ", fmt_result(want),
                             " got ", fmt_result(got)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hunt_head  = 8'h00;
            close_val  = 8'h00;
            pos_type   = 4'd1;
            pos_seq    = 4'd2;
            pos_len    = 4'd3;
            pos_cmd    = 4'd4;
            collecting = 1'b0;
            offset     = 0;
            hdr_type   = 8'h00;
            hdr_seq    = 8'h00;
            hdr_len    = 8'h00;
            hdr_cmd    = 8'h00;
            frame_results_due.delete();
            o_errors     = 0;
            o_bytes      = 0;
            o_results    = 0;
            o_bad_frames = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAD:     hunt_head = i_cfg_data;
                    CFG_END:      close_val = i_cfg_data;
                    CFG_TYPE_POS: pos_type  = i_cfg_data[3:0];
                    CFG_SEQ_POS:  pos_seq   = i_cfg_data[3:0];
                    CFG_LEN_POS:  pos_len   = i_cfg_data[3:0];
                    CFG_CMD_POS:  pos_cmd   = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                o_bytes++;
                parse_rx_byte(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
        end
        o_pending  = frame_results_due.size();
        o_in_frame = collecting;
    end

endmodule

[sim/tb_crc8_framed_command_parser.sv]
`timescale 1ns / 1ps

module tb_crc8_framed_command_parser;
    import cfcp_pkg::*;
    import cfcp_tb_crc_pkg::*;

    localparam int N_PHASES        = 5;
    localparam int BYTES_PER_PHASE = 94;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_END,
        FR_TOO_LONG,
        FR_CUT,
        FR_NONE
    } t_frame_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;

    cfcp_rx_if  rx();
    cfcp_res_if res();

    int   errors;
    int   pending;
    logic in_frame;
    int   n_bytes;
    int   n_results;
    int   n_bad;

    logic [7:0] cur_head = 8'h00;
    logic [7:0] cur_end  = 8'h00;
    logic [3:0] cur_type = 4'd1;
    logic [3:0] cur_seq  = 4'd2;
    logic [3:0] cur_len  = 4'd3;
    logic [3:0] cur_cmd  = 4'd4;

    bit idle_rx  = 1'b1;
    bit idle_res = 1'b1;
    bit hold_res = 1'b0;
    int bytes_sent   = 0;
    int stall_cycles = 0;

    crc8_framed_command_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx),
        .o_res      (res)
    );

    crc8_parser_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_rx         (rx),
        .i_res        (res),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_in_frame   (in_frame),
        .o_bytes      (n_bytes),
        .o_results    (n_results),
        .o_bad_frames (n_bad)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic put_rx(input logic [7:0] b);
        int gap;
        gap = idle_rx ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge i_clk);
        while (!rx.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] h, input logic [7:0] e,
                                input logic [3:0] t, input logic [3:0] s,
                                input logic [3:0] l, input logic [3:0] c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEAD;
        cfg_data <= h;
        @(negedge i_clk);
        cfg_idx  <= CFG_END;
        cfg_data <= e;
        @(negedge i_clk);
        cfg_idx  <= CFG_TYPE_POS;
        cfg_data <= {4'h0, t};
        @(negedge i_clk);
        cfg_idx  <= CFG_SEQ_POS;
        cfg_data <= {4'h0, s};
        @(negedge i_clk);
        cfg_idx  <= CFG_LEN_POS;
        cfg_data <= {4'h0, l};
        @(negedge i_clk);
        cfg_idx  <= CFG_CMD_POS;
        cfg_data <= {4'h0, c};
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_head = h;
        cur_end  = e;
        cur_type = t;
        cur_seq  = s;
        cur_len  = l;
        cur_cmd  = c;
    endtask

    task automatic send_frame(input t_frame_kind kind, input int force_len);
        logic [7:0] fb [0:BUF_BYTES];
        logic [7:0] crc;
        int         plen;
        int         lmax;
        int         close_at;
        int         n;
        int         k;
        for (k = 0; k <= BUF_BYTES; k++) begin
            fb[k] = rand_byte();
        end
        fb[0] = cur_head;
        lmax  = BUF_BYTES - 3 - cur_cmd;
        if (force_len >= 0) begin
            plen = force_len;
        end else if (kind == FR_TOO_LONG) begin
            plen = $urandom_range(255, lmax + 1);
        end else if ($urandom_range(0, 9) == 0) begin
            plen = $urandom_range(lmax, 0);
        end else begin
            plen = $urandom_range((lmax < 6) ? lmax : 6, 0);
        end
        if (cur_len != 0) begin
            fb[cur_len] = plen[7:0];
        end else begin
            plen = 0;
        end
        close_at = cur_cmd + plen + 2;
        if (cur_type > close_at) close_at = cur_type;
        if (cur_seq > close_at)  close_at = cur_seq;
        if (cur_len > close_at)  close_at = cur_len;
        if (close_at > BUF_BYTES - 1) begin
            n = BUF_BYTES + 1;
        end else begin
            crc = 8'h00;
            for (k = 0; k <= plen; k++) begin
                crc = crc8_update(crc, fb[cur_cmd + k]);
            end
            if (kind == FR_BAD_CRC) begin
                crc ^= 8'h01 << $urandom_range(7, 0);
            end
            // hold the length byte where the check bytes would land on it
            if (close_at - 1 != cur_len) begin
                fb[close_at - 1] = crc;
            end
            if (close_at != cur_len) begin
                fb[close_at] = cur_end;
                if (kind == FR_BAD_END) begin
                    fb[close_at] ^= 8'h01 << $urandom_range(7, 0);
                end
            end
            n = close_at + 1;
            if (kind == FR_CUT) begin
                n = $urandom_range(n - 1, 1);
            end
        end
        for (k = 0; k < n; k++) begin
            put_rx(fb[k]);
        end
    endtask

    task automatic drain_phase();
        rx.valid <= 1'b0;
        @(negedge i_clk);
        forever begin
            while (pending != 0) @(negedge i_clk);
            if (!in_frame) break;
            put_rx(rand_byte());
            rx.valid <= 1'b0;
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("crc8_framed_command_parser verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int gap;
        res.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_res) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_res = 1'b0;
            end
            gap = idle_res ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
            while (!res.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int          ph;
        int          r;
        logic [7:0]  b;
        t_frame_kind kind;
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_HEAD;
        cfg_data   = 8'h00;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: write_config(8'hFF, 8'h00, 4'd1, 4'd2, 4'd3, 4'd15);
                2: write_config(8'hA5, 8'hFF, 4'd15, 4'd14, 4'd13, 4'd1);
                3: write_config(8'h00, 8'($urandom), 4'd0, 4'd1, 4'd2, 4'd0);
                4: write_config(8'($urandom), 8'($urandom), 4'($urandom_range(15, 1)),
                                4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)),
                                4'($urandom_range(15, 1)));
                default: ;
            endcase
            idle_rx  = (ph != 1);
            idle_res = (ph != 3);

            if (ph == 0) begin
                send_frame(FR_GOOD, 0);
                send_frame(FR_GOOD, 1);
                send_frame(FR_BAD_CRC, 0);
                send_frame(FR_BAD_END, 0);
            end
            if (ph == 1 || ph == 3) begin
                send_frame(FR_TOO_LONG, -1);
            end
            if (ph == 2) begin
                // stall the result side on a long frame while bytes keep coming
                hold_res = 1'b1;
                send_frame(FR_GOOD, 40);
            end

            while (bytes_sent < (ph + 1) * BYTES_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 62)      kind = FR_GOOD;
                else if (r < 72) kind = FR_BAD_CRC;
                else if (r < 82) kind = FR_BAD_END;
                else if (r < 84) kind = FR_TOO_LONG;
                else if (r < 94) kind = FR_CUT;
                else             kind = FR_NONE;
                repeat ($urandom_range(0, 2)) begin
                    b = rand_byte();
                    if (b == cur_head && $urandom_range(0, 3) != 0) begin
                        b = ~b;
                    end
                    put_rx(b);
                end
                if (kind != FR_NONE) begin
                    send_frame(kind, -1);
                end
            end
            drain_phase();
        end

        repeat (50) @(negedge i_clk);
        $display("covered %0d received bytes under %0d register settings", n_bytes, N_PHASES);
        $display("checked %0d results, %0d of them frame error reports", n_results, n_bad);
        if (errors == 0 && pending == 0) begin
            $display("crc8_framed_command_parser verification clean");
        end else begin
            $display("%0d mismatches, %0d results still due", errors, pending);
            $display("crc8_framed_command_parser verification failed");
        end
        $finish;
    end

endmodule
